### sv/clsu_pkg.sv
`default_nettype none
package clsu_pkg;

  localparam logic [4:0] OP_LD_HL_N8    = 5'd0;
  localparam logic [4:0] OP_LD_R_R      = 5'd1;
  localparam logic [4:0] OP_LD_R_N8     = 5'd2;
  localparam logic [4:0] OP_LD_RR_N16   = 5'd3;
  localparam logic [4:0] OP_LD_HL_R     = 5'd4;
  localparam logic [4:0] OP_LD_R_HL     = 5'd5;
  localparam logic [4:0] OP_LD_RR_A     = 5'd6;
  localparam logic [4:0] OP_LD_N16_A    = 5'd7;
  localparam logic [4:0] OP_LDH_N16_A   = 5'd8;
  localparam logic [4:0] OP_LDH_C_A     = 5'd9;
  localparam logic [4:0] OP_LD_A_RR     = 5'd10;
  localparam logic [4:0] OP_LD_A_N16    = 5'd11;
  localparam logic [4:0] OP_LDH_A_N16   = 5'd12;
  localparam logic [4:0] OP_LDH_A_C     = 5'd13;
  localparam logic [4:0] OP_LD_HLI_A    = 5'd14;
  localparam logic [4:0] OP_LD_HLD_A    = 5'd15;
  localparam logic [4:0] OP_LD_A_HLD    = 5'd16;
  localparam logic [4:0] OP_LD_A_HLI    = 5'd17;
  localparam logic [4:0] OP_LD_SP_N16   = 5'd18;
  localparam logic [4:0] OP_LD_N16_SP   = 5'd19;
  localparam logic [4:0] OP_LD_HL_SPE   = 5'd20;
  localparam logic [4:0] OP_LD_SP_HL    = 5'd21;
  localparam logic [4:0] OP_LDH_A_N8    = 5'd22;
  localparam logic [4:0] OP_LDH_N8_A    = 5'd23;
  localparam logic [4:0] OP_READ_RESP   = 5'd24;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_REG     = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_A = 3'd6;

  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  localparam logic [3:0] RIDX_PAIR_BASE = 4'd7;
  localparam logic [3:0] RIDX_HL        = 4'd9;

  localparam logic [1:0] ADJ_NONE = 2'd0;
  localparam logic [1:0] ADJ_INC  = 2'd1;
  localparam logic [1:0] ADJ_DEC  = 2'd2;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  typedef struct packed {
    logic [4:0]        opcode;
    logic [2:0]        dst_reg;
    logic [2:0]        src_reg;
    logic [1:0]        pair_sel;
    logic [15:0]       imm16;
    logic [7:0]        imm8;
    logic signed [7:0] offset;
    logic [7:0]        read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic [3:0]  flag_bits;
    logic        last;
  } out_item_t;

endpackage
`default_nettype wire

### sv/cpu_load_store_unit.sv
`default_nettype none
// Load/store unit for the 8-bit CPU load family. One instruction or memory
// read response is taken per cycle while in_stall is low; register state updates
// at the input transfer and the results land in a two-entry result buffer, so a
// result shows on out_ in the cycle after its item. Items with one result sustain
// one per cycle while out_stall is low; LD (HL+/-),A, LD (n16),SP and responses
// that adjust HL give two results and hold the input while the buffer drains.
// A memory load emits a read request; the next opcode-24 item completes it,
// and any instruction that arrives before that is dropped with a kind-3 result.
module cpu_load_store_unit
  import clsu_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire           out_stall,
  output out_item_t     out_data
);

  logic [6:0][7:0] regs_r, regs_nxt;
  logic [15:0]     sp_r, sp_nxt;
  logic [3:0]      flags_r, flags_nxt;
  logic            pend_r, pend_nxt;
  logic [2:0]      pdst_r, pdst_nxt;
  logic [1:0]      padj_r, padj_nxt;

  out_item_t       slot0_r, slot1_r;
  logic [1:0]      cnt_r;

  out_item_t       res0, res1;
  logic            two;

  logic            in_xfer, out_xfer;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign out_xfer  = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall));
  assign in_xfer   = in_valid && !in_stall;

  function automatic logic [2:0] clip_reg(input logic [2:0] r);
    return (r == 3'd7) ? REG_A : r;
  endfunction

  function automatic logic [15:0] pair_of(input logic [6:0][7:0] rf,
                                          input logic [15:0] sp,
                                          input logic [1:0] p);
    logic [15:0] v;
    case (p)
      2'd0:    v = {rf[0], rf[1]};
      2'd1:    v = {rf[2], rf[3]};
      2'd2:    v = {rf[4], rf[5]};
      default: v = sp;
    endcase
    return v;
  endfunction

  function automatic out_item_t mk(input logic [1:0] kind, input logic [15:0] addr,
                                   input logic [7:0] wd, input logic [3:0] ri,
                                   input logic [15:0] rv, input logic last);
    out_item_t o;
    o.kind       = kind;
    o.address    = addr;
    o.write_data = wd;
    o.reg_index  = ri;
    o.reg_value  = rv;
    o.flag_bits  = 4'd0;
    o.last       = last;
    return o;
  endfunction

  always_comb begin
    logic [2:0]  dst, src, pd;
    logic [7:0]  a;
    logic [15:0] hl, hl2, pv, hp_c, hp_n8, ext, spr;
    logic [4:0]  hsum;
    logic [8:0]  csum;
    regs_nxt  = regs_r;
    sp_nxt    = sp_r;
    flags_nxt = flags_r;
    pend_nxt  = pend_r;
    pdst_nxt  = pdst_r;
    padj_nxt  = padj_r;
    two       = 1'b0;
    dst   = clip_reg(in_data.dst_reg);
    src   = clip_reg(in_data.src_reg);
    pd    = clip_reg(pdst_r);
    a     = regs_r[REG_A];
    hl    = {regs_r[REG_H], regs_r[REG_L]};
    pv    = pair_of(regs_r, sp_r, in_data.pair_sel);
    hp_c  = HIGH_PAGE | {8'd0, regs_r[REG_C]};
    hp_n8 = HIGH_PAGE | {8'd0, in_data.imm8};
    ext   = {{8{in_data.offset[7]}}, in_data.offset};
    spr   = sp_r + ext;
    hsum  = {1'b0, sp_r[3:0]} + {1'b0, in_data.offset[3:0]};
    csum  = {1'b0, sp_r[7:0]} + {1'b0, in_data.offset};
    hl2   = 16'd0;
    res0  = mk(KIND_NONE, 16'd0, 8'd0, 4'd0, 16'd0, 1'b1);
    res1  = mk(KIND_NONE, 16'd0, 8'd0, 4'd0, 16'd0, 1'b1);

    if (in_data.opcode == OP_READ_RESP) begin
      if (pend_r) begin
        pend_nxt     = 1'b0;
        padj_nxt     = ADJ_NONE;
        regs_nxt[pd] = in_data.read_data;
        res0 = mk(KIND_REG, 16'd0, 8'd0, {1'b0, pd}, {8'd0, in_data.read_data}, 1'b1);
        if (padj_r == ADJ_INC || padj_r == ADJ_DEC) begin
          // HL is read after the loaded byte lands (matters when dest is H or L)
          hl2 = {regs_nxt[REG_H], regs_nxt[REG_L]};
          hl2 = (padj_r == ADJ_INC) ? hl2 + 16'd1 : hl2 - 16'd1;
          regs_nxt[REG_H] = hl2[15:8];
          regs_nxt[REG_L] = hl2[7:0];
          res0.last = 1'b0;
          res1 = mk(KIND_REG, 16'd0, 8'd0, RIDX_HL, hl2, 1'b1);
          two  = 1'b1;
        end
      end
    end else if (!pend_r) begin
      case (in_data.opcode)
        OP_LD_HL_N8: res0 = mk(KIND_WRITE, hl, in_data.imm8, 4'd0, 16'd0, 1'b1);
        OP_LD_R_R: begin
          regs_nxt[dst] = regs_r[src];
          res0 = mk(KIND_REG, 16'd0, 8'd0, {1'b0, dst}, {8'd0, regs_r[src]}, 1'b1);
        end
        OP_LD_R_N8: begin
          regs_nxt[dst] = in_data.imm8;
          res0 = mk(KIND_REG, 16'd0, 8'd0, {1'b0, dst}, {8'd0, in_data.imm8}, 1'b1);
        end
        OP_LD_RR_N16, OP_LD_SP_N16, OP_LD_SP_HL, OP_LD_HL_SPE: begin
          logic [1:0]  p;
          logic [15:0] v;
          p = in_data.pair_sel;
          v = in_data.imm16;
          if (in_data.opcode == OP_LD_SP_N16) begin
            p = PAIR_SP;
          end else if (in_data.opcode == OP_LD_SP_HL) begin
            p = PAIR_SP;
            v = hl;
          end else if (in_data.opcode == OP_LD_HL_SPE) begin
            p = PAIR_HL;
            v = spr;
            flags_nxt = {2'b00, hsum[4], csum[8]};
          end
          case (p)
            2'd0:    begin regs_nxt[0] = v[15:8]; regs_nxt[1] = v[7:0]; end
            2'd1:    begin regs_nxt[2] = v[15:8]; regs_nxt[3] = v[7:0]; end
            2'd2:    begin regs_nxt[4] = v[15:8]; regs_nxt[5] = v[7:0]; end
            default: sp_nxt = v;
          endcase
          res0 = mk(KIND_REG, 16'd0, 8'd0, RIDX_PAIR_BASE + {2'b00, p}, v, 1'b1);
        end
        OP_LD_HL_R:  res0 = mk(KIND_WRITE, hl, regs_r[src], 4'd0, 16'd0, 1'b1);
        OP_LD_RR_A:  res0 = mk(KIND_WRITE, pv, a, 4'd0, 16'd0, 1'b1);
        OP_LD_N16_A: res0 = mk(KIND_WRITE, in_data.imm16, a, 4'd0, 16'd0, 1'b1);
        OP_LDH_N16_A: begin
          if (in_data.imm16 >= HIGH_PAGE)
            res0 = mk(KIND_WRITE, in_data.imm16, a, 4'd0, 16'd0, 1'b1);
        end
        OP_LDH_C_A:  res0 = mk(KIND_WRITE, hp_c, a, 4'd0, 16'd0, 1'b1);
        OP_LDH_N8_A: res0 = mk(KIND_WRITE, hp_n8, a, 4'd0, 16'd0, 1'b1);
        OP_LD_R_HL, OP_LD_A_RR, OP_LD_A_N16, OP_LDH_A_N16, OP_LDH_A_C,
        OP_LD_A_HLD, OP_LD_A_HLI, OP_LDH_A_N8: begin
          logic [15:0] ra;
          logic        go;
          go = 1'b1;
          ra = hl;
          pdst_nxt = REG_A;
          padj_nxt = ADJ_NONE;
          case (in_data.opcode)
            OP_LD_R_HL:   pdst_nxt = dst;
            OP_LD_A_RR:   ra = pv;
            OP_LD_A_N16:  ra = in_data.imm16;
            OP_LDH_A_N16: begin
              ra = in_data.imm16;
              go = (in_data.imm16 >= HIGH_PAGE);
            end
            OP_LDH_A_C:   ra = hp_c;
            OP_LD_A_HLD:  padj_nxt = ADJ_DEC;
            OP_LD_A_HLI:  padj_nxt = ADJ_INC;
            default:      ra = hp_n8;
          endcase
          if (go) begin
            pend_nxt = 1'b1;
            res0 = mk(KIND_READ, ra, 8'd0, 4'd0, 16'd0, 1'b1);
          end else begin
            pdst_nxt = pdst_r;
            padj_nxt = padj_r;
          end
        end
        OP_LD_HLI_A, OP_LD_HLD_A: begin
          hl2 = (in_data.opcode == OP_LD_HLI_A) ? hl + 16'd1 : hl - 16'd1;
          regs_nxt[REG_H] = hl2[15:8];
          regs_nxt[REG_L] = hl2[7:0];
          res0 = mk(KIND_WRITE, hl, a, 4'd0, 16'd0, 1'b0);
          res1 = mk(KIND_REG, 16'd0, 8'd0, RIDX_HL, hl2, 1'b1);
          two  = 1'b1;
        end
        OP_LD_N16_SP: begin
          res0 = mk(KIND_WRITE, in_data.imm16, sp_r[7:0], 4'd0, 16'd0, 1'b0);
          res1 = mk(KIND_WRITE, in_data.imm16 + 16'd1, sp_r[15:8], 4'd0, 16'd0, 1'b1);
          two  = 1'b1;
        end
        default: ;
      endcase
    end
    res0.flag_bits = flags_nxt;
    res1.flag_bits = flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r  <= '0;
      sp_r    <= '0;
      flags_r <= '0;
      pend_r  <= 1'b0;
      pdst_r  <= '0;
      padj_r  <= ADJ_NONE;
      cnt_r   <= 2'd0;
    end else begin
      if (in_xfer) begin
        regs_r  <= regs_nxt;
        sp_r    <= sp_nxt;
        flags_r <= flags_nxt;
        pend_r  <= pend_nxt;
        pdst_r  <= pdst_nxt;
        padj_r  <= padj_nxt;
        cnt_r   <= two ? 2'd2 : 2'd1;
      end else if (out_xfer) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      slot0_r <= res0;
      slot1_r <= res1;
    end else if (out_xfer) begin
      slot0_r <= slot1_r;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result buffer count out of range");

  a_in_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid) else $error("accepted item produced no result");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!slot0_r.last && slot1_r.last))
    else $error("two-result item has wrong last marking");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_xfer) else $error("input taken with buffer full");

endmodule
`default_nettype wire

### verif/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import clsu_pkg::*;

  localparam logic [2:0] REG_CODE_SEVEN = 3'd7;
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  cpu_load_store_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the architectural state
  logic [7:0]  byte_file [7] = '{default: 8'h00};
  logic [15:0] sp_val = 16'h0000;
  logic [3:0]  flag_val = 4'h0;
  logic        load_pending = 1'b0;
  logic [2:0]  load_dest = 3'd0;
  logic [1:0]  load_adjust = ADJ_NONE;

  out_item_t   expected_q [$];
  int unsigned mismatch_count = 0;
  logic        item_had_effect = 1'b0;
  bit          idle_enable = 1'b1;
  int unsigned hold_len = 0;

  function automatic logic [15:0] pair_value(logic [1:0] p);
    if (p == PAIR_SP) return sp_val;
    return {byte_file[{p, 1'b0}], byte_file[{p, 1'b1}]};
  endfunction

  function automatic void set_pair(logic [1:0] p, logic [15:0] v);
    if (p == PAIR_SP) begin
      sp_val = v;
    end else begin
      byte_file[{p, 1'b0}] = v[15:8];
      byte_file[{p, 1'b1}] = v[7:0];
    end
  endfunction

  function automatic void expect_result(logic [1:0] kind, logic [15:0] addr,
                                        logic [7:0] wdata, logic [3:0] ridx,
                                        logic [15:0] rval, logic lst);
    out_item_t r;
    r.kind       = kind;
    r.address    = addr;
    r.write_data = wdata;
    r.reg_index  = ridx;
    r.reg_value  = rval;
    r.flag_bits  = flag_val;
    r.last       = lst;
    expected_q.push_back(r);
  endfunction

  function automatic void expect_none();
    expect_result(KIND_NONE, '0, '0, '0, '0, 1'b1);
  endfunction

  function automatic void expect_write(logic [15:0] addr, logic [7:0] data, logic lst);
    expect_result(KIND_WRITE, addr, data, '0, '0, lst);
  endfunction

  function automatic void set_byte(logic [2:0] r, logic [7:0] v);
    byte_file[r] = v;
    expect_result(KIND_REG, '0, '0, {1'b0, r}, {8'h00, v}, 1'b1);
  endfunction

  function automatic void set_word(logic [1:0] p, logic [15:0] v);
    set_pair(p, v);
    expect_result(KIND_REG, '0, '0, RIDX_PAIR_BASE + {2'b00, p}, pair_value(p), 1'b1);
  endfunction

  function automatic void start_read(logic [15:0] addr, logic [2:0] dest, logic [1:0] adj);
    load_pending = 1'b1;
    load_dest    = dest;
    load_adjust  = adj;
    expect_result(KIND_READ, addr, '0, '0, '0, 1'b1);
  endfunction

  function automatic void step_hl(logic [1:0] adj);
    logic [15:0] hl;
    hl = pair_value(PAIR_HL);
    hl = (adj == ADJ_INC) ? hl + 16'd1 : hl - 16'd1;
    set_pair(PAIR_HL, hl);
    expect_result(KIND_REG, '0, '0, RIDX_HL, hl, 1'b1);
  endfunction

  // Returns 0 when the item is dropped with a kind-none result
  function automatic logic predict_load_store(in_item_t it);
    logic [2:0]  dst, src, dest;
    logic [7:0]  acc;
    logic [15:0] hl, sum;
    logic [1:0]  adj;
    logic [4:0]  low_nib;
    logic [8:0]  low_byte;
    dst = (it.dst_reg > REG_A) ? REG_A : it.dst_reg;
    src = (it.src_reg > REG_A) ? REG_A : it.src_reg;
    acc = byte_file[REG_A];
    hl  = pair_value(PAIR_HL);

    if (it.opcode == OP_READ_RESP) begin
      if (!load_pending) begin
        expect_none();
        return 1'b0;
      end
      load_pending = 1'b0;
      dest = (load_dest > REG_A) ? REG_A : load_dest;
      adj = load_adjust;
      load_adjust = ADJ_NONE;
      byte_file[dest] = it.read_data;
      if (adj == ADJ_INC || adj == ADJ_DEC) begin
        expect_result(KIND_REG, '0, '0, {1'b0, dest}, {8'h00, it.read_data}, 1'b0);
        step_hl(adj);
      end else begin
        expect_result(KIND_REG, '0, '0, {1'b0, dest}, {8'h00, it.read_data}, 1'b1);
      end
      return 1'b1;
    end
    if (it.opcode > OP_READ_RESP || load_pending) begin
      expect_none();
      return 1'b0;
    end

    case (it.opcode)
      OP_LD_HL_N8:  expect_write(hl, it.imm8, 1'b1);
      OP_LD_R_R:    set_byte(dst, byte_file[src]);
      OP_LD_R_N8:   set_byte(dst, it.imm8);
      OP_LD_RR_N16: set_word(it.pair_sel, it.imm16);
      OP_LD_HL_R:   expect_write(hl, byte_file[src], 1'b1);
      OP_LD_R_HL:   start_read(hl, dst, ADJ_NONE);
      OP_LD_RR_A:   expect_write(pair_value(it.pair_sel), acc, 1'b1);
      OP_LD_N16_A:  expect_write(it.imm16, acc, 1'b1);
      OP_LDH_N16_A: begin
        if (it.imm16 < HIGH_PAGE) begin
          expect_none();
          return 1'b0;
        end
        expect_write(it.imm16, acc, 1'b1);
      end
      OP_LDH_C_A:   expect_write(HIGH_PAGE + {8'h00, byte_file[REG_C]}, acc, 1'b1);
      OP_LD_A_RR:   start_read(pair_value(it.pair_sel), REG_A, ADJ_NONE);
      OP_LD_A_N16:  start_read(it.imm16, REG_A, ADJ_NONE);
      OP_LDH_A_N16: begin
        if (it.imm16 < HIGH_PAGE) begin
          expect_none();
          return 1'b0;
        end
        start_read(it.imm16, REG_A, ADJ_NONE);
      end
      OP_LDH_A_C:   start_read(HIGH_PAGE + {8'h00, byte_file[REG_C]}, REG_A, ADJ_NONE);
      OP_LD_HLI_A: begin
        expect_write(hl, acc, 1'b0);
        step_hl(ADJ_INC);
      end
      OP_LD_HLD_A: begin
        expect_write(hl, acc, 1'b0);
        step_hl(ADJ_DEC);
      end
      OP_LD_A_HLD:  start_read(hl, REG_A, ADJ_DEC);
      OP_LD_A_HLI:  start_read(hl, REG_A, ADJ_INC);
      OP_LD_SP_N16: set_word(PAIR_SP, it.imm16);
      OP_LD_N16_SP: begin
        expect_write(it.imm16, sp_val[7:0], 1'b0);
        expect_write(it.imm16 + 16'd1, sp_val[15:8], 1'b1);
      end
      OP_LD_HL_SPE: begin
        low_nib  = {1'b0, sp_val[3:0]} + {1'b0, it.offset[3:0]};
        low_byte = {1'b0, sp_val[7:0]} + {1'b0, it.offset};
        sum      = sp_val + {{8{it.offset[7]}}, it.offset};
        // Z and N cleared, H and C from the low byte
        flag_val = {2'b00, low_nib[4], low_byte[8]};
        set_word(PAIR_HL, sum);
      end
      OP_LD_SP_HL:  set_word(PAIR_SP, hl);
      OP_LDH_A_N8:  start_read(HIGH_PAGE + {8'h00, it.imm8}, REG_A, ADJ_NONE);
      default:      expect_write(HIGH_PAGE + {8'h00, it.imm8}, acc, 1'b1);
    endcase
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: 0x%0h", out_data);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_data.kind));
        check_field("address", want.address, out_data.address);
        check_field("write_data", 16'(want.write_data), 16'(out_data.write_data));
        check_field("reg_index", 16'(want.reg_index), 16'(out_data.reg_index));
        check_field("reg_value", want.reg_value, out_data.reg_value);
        check_field("flag_bits", 16'(want.flag_bits), 16'(out_data.flag_bits));
        check_field("last", 16'(want.last), 16'(out_data.last));
      end
    end
  end

  // Receiver back-pressure; a requested hold-off overrides the random pattern
  initial begin : result_stall_gen
    int unsigned pick, span;
    logic stall_now;
    while (!rst_n) @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (hold_len != 0) begin
        stall_now = 1'b1;
        span = hold_len;
        hold_len = 0;
      end else if (!idle_enable || pick < 45) begin
        stall_now = 1'b0;
        span = idle_enable ? $urandom_range(1, 20) : 1;
      end else if (pick < 88) begin
        stall_now = 1'b1;
        span = $urandom_range(1, 3);
      end else begin
        stall_now = 1'b1;
        span = $urandom_range(8, 40);
      end
      out_stall <= stall_now;
      repeat (span) @(posedge clk);
    end
  end

  function automatic int unsigned gap_len();
    int unsigned pick;
    if (!idle_enable) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic idle_cycles(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    item_had_effect = predict_load_store(it);
    gap = gap_len();
    if (gap != 0) idle_cycles(gap);
  endtask

  // Always advances to a clock edge before checking, so valid is never driven twice in a step
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  function automatic in_item_t op_item(logic [4:0] op);
    logic [63:0] bits;
    in_item_t it;
    bits = {$urandom, $urandom};
    it = bits[$bits(in_item_t)-1:0];
    it.opcode = op;
    return it;
  endfunction

  task automatic send_resp(input logic [7:0] data);
    in_item_t it;
    it = op_item(OP_READ_RESP);
    it.read_data = data;
    send_item(it);
  endtask

  // Mostly well-formed: a pending load is usually followed by its response
  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick;
    it = op_item(OP_LD_HL_N8);
    pick = $urandom_range(0, 99);
    if (load_pending) begin
      if (pick < 88) it.opcode = OP_READ_RESP;
      else it.opcode = 5'($urandom);
    end else if (pick < 92) begin
      it.opcode = 5'($urandom_range(0, OP_LDH_N8_A));
    end else if (pick < 96) begin
      it.opcode = OP_READ_RESP;
    end else begin
      it.opcode = OP_READ_RESP + 5'($urandom_range(1, 7));
    end
    if ((it.opcode == OP_LDH_N16_A || it.opcode == OP_LDH_A_N16) && pick[0])
      it.imm16[15:8] = 8'hFF;
    return it;
  endfunction

  task automatic test_store_and_move_forms();
    in_item_t it;
    it = op_item(OP_LD_SP_N16); it.imm16 = 16'hFFFF; send_item(it);
    it = op_item(OP_LD_N16_SP); it.imm16 = 16'hFFFF; send_item(it);
    it = op_item(OP_LD_RR_N16); it.pair_sel = PAIR_BC; it.imm16 = 16'hFFFF; send_item(it);
    it = op_item(OP_LD_RR_N16); it.pair_sel = PAIR_HL; it.imm16 = 16'h0000; send_item(it);
    it = op_item(OP_LD_R_N8); it.dst_reg = REG_A; it.imm8 = 8'hFF; send_item(it);
    it = op_item(OP_LD_HL_N8); it.imm8 = 8'h00; send_item(it);
    it = op_item(OP_LD_HL_R); it.src_reg = REG_C; send_item(it);
    it = op_item(OP_LD_R_R); it.dst_reg = REG_H; it.src_reg = REG_A; send_item(it);
    it = op_item(OP_LD_RR_A); it.pair_sel = PAIR_BC; send_item(it);
    it = op_item(OP_LD_N16_A); it.imm16 = 16'h0000; send_item(it);
    it = op_item(OP_LDH_N16_A); it.imm16 = HIGH_PAGE; send_item(it);
    it = op_item(OP_LDH_C_A); send_item(it);
    it = op_item(OP_LDH_N8_A); it.imm8 = 8'hFF; send_item(it);
    it = op_item(OP_LD_HLI_A); send_item(it);
    it = op_item(OP_LD_HLD_A); send_item(it);
    it = op_item(OP_LD_SP_HL); send_item(it);
    it = op_item(OP_LD_SP_N16); it.imm16 = 16'h00FF; send_item(it);
    it = op_item(OP_LD_HL_SPE); it.offset = 8'sh7F; send_item(it);
    it = op_item(OP_LD_HL_SPE); it.offset = 8'sh80; send_item(it);
    wait_for_drain();
  endtask

  task automatic test_load_forms();
    in_item_t it;
    // HL wraps both ways across the post-increment and post-decrement loads
    it = op_item(OP_LD_RR_N16); it.pair_sel = PAIR_HL; it.imm16 = 16'hFFFF; send_item(it);
    it = op_item(OP_LD_A_HLI); send_item(it); send_resp(8'h00);
    it = op_item(OP_LD_A_HLD); send_item(it); send_resp(8'hFF);
    it = op_item(OP_LD_R_HL); it.dst_reg = REG_C; send_item(it); send_resp(8'hA5);
    it = op_item(OP_LD_A_RR); it.pair_sel = PAIR_DE; send_item(it); send_resp(8'h5A);
    it = op_item(OP_LD_A_N16); it.imm16 = 16'h0000; send_item(it); send_resp(8'h01);
    it = op_item(OP_LDH_A_N16); it.imm16 = 16'hFFFF; send_item(it); send_resp(8'h80);
    it = op_item(OP_LDH_A_C); send_item(it); send_resp(8'h7F);
    it = op_item(OP_LDH_A_N8); it.imm8 = 8'hFF; send_item(it); send_resp(8'hFE);
    wait_for_drain();
  endtask

  task automatic test_special_cases();
    in_item_t it;
    it = op_item(OP_LD_R_N8); it.dst_reg = REG_CODE_SEVEN; it.imm8 = 8'h3C; send_item(it);
    it = op_item(OP_LD_R_R); it.dst_reg = REG_L; it.src_reg = REG_CODE_SEVEN; send_item(it);
    it = op_item(OP_LDH_N16_A); it.imm16 = 16'hFEFF; send_item(it);
    it = op_item(OP_LDH_A_N16); it.imm16 = 16'h0000; send_item(it);
    // instruction arriving while a load is outstanding is dropped
    it = op_item(OP_LD_A_N16); it.imm16 = 16'h1234; send_item(it);
    it = op_item(OP_LD_N16_A); send_item(it);
    send_resp(8'hC3);
    send_resp(8'h00);
    it = op_item(OP_READ_RESP + 5'd1); send_item(it);
    it = op_item('1); send_item(it);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned done_items = 0;
    while (done_items < n_items) begin
      send_item(random_item());
      if (item_had_effect) begin
        done_items++;
        if (done_items % 150 == 0) wait_for_drain();
      end
    end
    wait_for_drain();
  endtask

  task automatic test_back_to_back(input int unsigned n_items);
    int unsigned k;
    idle_enable = 1'b0;
    for (k = 0; k < n_items; k++) send_item(random_item());
    idle_enable = 1'b1;
    wait_for_drain();
  endtask

  task automatic test_output_hold_off();
    int unsigned k;
    idle_enable = 1'b0;
    hold_len = 200;
    for (k = 0; k < 40; k++) send_item(random_item());
    idle_enable = 1'b1;
    wait_for_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_store_and_move_forms();
    test_load_forms();
    test_special_cases();
    test_random_traffic(600);
    test_back_to_back(150);
    test_output_hold_off();
    // catch stray results after the last expected one
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire
